/* src/fic_pkg.sv */
// shared types, constants and rounding function for the float and integer conversion unit
package fic_pkg;

  localparam logic [2:0] ActToI64  = 3'd0;
  localparam logic [2:0] ActToI64T = 3'd1;
  localparam logic [2:0] ActToI32  = 3'd2;
  localparam logic [2:0] ActToI32T = 3'd3;
  localparam logic [2:0] ActToDbl  = 3'd4;
  localparam logic [2:0] ActClear  = 3'd5;

  localparam logic [1:0] RmNearest = 2'd0;
  localparam logic [1:0] RmZero    = 2'd1;
  localparam logic [1:0] RmPlus    = 2'd2;
  localparam logic [1:0] RmMinus   = 2'd3;

  typedef struct packed {
    logic [2:0]  action;
    logic [63:0] operand_bits;
  } fic_in_t;

  typedef struct packed {
    logic [63:0] result_bits;
    logic        fraction_inexact;
    logic        fraction_rounded;
    logic        invalid_now;
    logic        summary_flag;
    logic        inexact_flag;
    logic        invalid_flag;
  } fic_out_t;

  // per-item result before the sticky flags are folded in
  typedef struct packed {
    logic [63:0] res;
    logic        fi;
    logic        fr;
    logic        inv;
  } fic_conv_t;

  // round-up decision; cmp_gt / cmp_eq describe the remainder against half
  function automatic logic round_up(logic [1:0] mode, logic neg, logic nz,
                                    logic cmp_gt, logic cmp_eq, logic lsb);
    logic r;
    begin
      case (mode)
        RmNearest: r = cmp_gt | (cmp_eq & lsb);
        RmZero:    r = 1'b0;
        RmPlus:    r = nz & ~neg;
        RmMinus:   r = nz & neg;
        default:   r = 1'b0;
      endcase
      return r;
    end
  endfunction

endpackage

/* src/fic_to_int.sv */
// double to signed 64-bit or 32-bit integer
module fic_to_int import fic_pkg::*; (
  input  logic [63:0] b_i,
  input  logic        wide_i,
  input  logic [1:0]  mode_i,
  output fic_conv_t   conv_o
);

  logic        neg;
  logic [10:0] e;
  logic [51:0] frac;
  logic [52:0] mant;
  logic [63:0] pmax, nmax, ip, m, rem, half, kmask, sh_res;
  logic [6:0]  k;
  logic        up, nz, big, ovf;

  // field split, range decode and rounding
  always_comb begin
    neg  = b_i[63];
    e    = b_i[62:52];
    frac = b_i[51:0];
    mant = {(e != 11'd0), frac};
    pmax = wide_i ? 64'h7FFF_FFFF_FFFF_FFFF : 64'h0000_0000_7FFF_FFFF;
    nmax = wide_i ? 64'h8000_0000_0000_0000 : 64'h0000_0000_8000_0000;
    // shift >= 11 means e >= 1086
    big  = (e >= 11'd1086);
    k    = 7'd0;
    ip   = 64'd0;
    rem  = 64'd0;
    half = 64'd0;
    kmask = 64'd0;
    sh_res = 64'd0;
    up   = 1'b0;
    nz   = 1'b0;
    if (e >= 11'd1075) begin
      sh_res = {11'd0, mant} << (e - 11'd1075);
      m = sh_res;
    end else begin
      // k = 1075 - e, saturated at 64
      if (e <= 11'd1011) begin
        k = 7'd64;
        ip = 64'd0;
        rem = {11'd0, mant};
        nz = (rem != 64'd0);
        up = round_up(mode_i, neg, nz, 1'b0, 1'b0, 1'b0);
      end else begin
        k = 7'(11'd1075 - e);
        kmask = (64'd1 << k[5:0]) - 64'd1;
        half = 64'd1 << (k[5:0] - 6'd1);
        ip = {11'd0, mant} >> k[5:0];
        rem = {11'd0, mant} & kmask;
        nz = (rem != 64'd0);
        up = round_up(mode_i, neg, nz, rem > half, rem == half, ip[0]);
      end
      m = ip + {63'd0, up};
    end
    ovf = neg ? (m > nmax) : (m > pmax);
  end

  // result selection
  always_comb begin
    conv_o = '0;
    if (e == 11'h7FF) begin
      conv_o.inv = 1'b1;
      conv_o.res = (frac != 52'd0 || neg) ? nmax : pmax;
    end else if (big) begin
      if (wide_i && neg && e == 11'd1086 && frac == 52'd0) begin
        conv_o.res = 64'h8000_0000_0000_0000;
      end else begin
        conv_o.inv = 1'b1;
        conv_o.res = neg ? nmax : pmax;
      end
    end else if (ovf) begin
      conv_o.inv = 1'b1;
      conv_o.res = neg ? nmax : pmax;
    end else begin
      conv_o.res = neg ? (64'd0 - m) : m;
      if (!wide_i) conv_o.res[63:32] = 32'd0;
      conv_o.fi = nz;
      conv_o.fr = up;
    end
  end

endmodule

/* src/fic_to_dbl.sv */
// signed 64-bit integer to double
module fic_to_dbl import fic_pkg::*; (
  input  logic [63:0] x_i,
  input  logic [1:0]  mode_i,
  output fic_conv_t   conv_o
);

  logic        neg, up, nz;
  logic [63:0] mag, norm, rem, half;
  logic [5:0]  p, lz;
  logic [53:0] ip;
  logic [10:0] ex;

  // leading-one position by priority encoder, then normalization and rounding
  always_comb begin
    neg = x_i[63];
    mag = neg ? (64'd0 - x_i) : x_i;
    lz  = 6'd0;
    for (int i = 0; i < 64; i++) begin
      if (mag[i]) lz = 6'(63 - i);
    end
    p    = 6'd63 - lz;
    norm = mag << lz;
    // mantissa is norm[63:11], remainder norm[10:0]
    rem  = {53'd0, norm[10:0]};
    half = 64'h400;
    nz   = (rem != 64'd0);
    up   = round_up(mode_i, neg, nz, rem > half, rem == half, norm[11]);
    ip   = {1'b0, norm[63:11]} + {53'd0, up};
    ex   = 11'd1023 + {5'd0, p};
    if (ip[53]) begin
      ip = ip >> 1;
      ex = ex + 11'd1;
    end
  end

  // pack
  always_comb begin
    conv_o = '0;
    if (mag != 64'd0) begin
      conv_o.res = {neg, ex, ip[51:0]};
      conv_o.fi  = nz;
      conv_o.fr  = up;
    end
  end

endmodule

/* src/float_int_converter.sv */
// top level of the float and integer conversion unit
//  channel | dir | handshake          | beat
//  in      | in  | in_valid_i/stall_o | fic_in_t
//  out     | out | out_valid_o/stall_i| fic_out_t
//  cfg     | in  | cfg_valid_i/ready_o| rounding mode
// conversion logic on the accepted beat feeds the result register
// result valid on the cycle after the input beat; throughput one beat a cycle while the output does not stall
// reset clears valid, sticky flags and rounding mode
// a stalled result holds; input is taken whenever the result slot is empty or drains
module float_int_converter import fic_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  fic_in_t    in_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output fic_out_t   out_data_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_data_i
);

  logic [1:0] mode_q;
  logic       vld_q;
  fic_out_t   out_q, out_d;
  logic       sum_q, inx_q, inv_q, sum_d, inx_d, inv_d;
  logic       take, wide, trunc;
  logic [1:0] mode_eff;
  fic_conv_t  ci, cd, cv;

  assign in_stall_o  = vld_q & out_stall_i;
  assign take        = in_valid_i & ~in_stall_o;
  assign cfg_ready_o = 1'b1;

  // operation decode
  assign wide     = (in_data_i.action == ActToI64) || (in_data_i.action == ActToI64T);
  assign trunc    = (in_data_i.action == ActToI64T) || (in_data_i.action == ActToI32T);
  assign mode_eff = trunc ? RmZero : mode_q;

  fic_to_int u_int (.b_i(in_data_i.operand_bits), .wide_i(wide), .mode_i(mode_eff),
                    .conv_o(ci));
  fic_to_dbl u_dbl (.x_i(in_data_i.operand_bits), .mode_i(mode_q), .conv_o(cd));

  // result select and sticky update
  always_comb begin
    case (in_data_i.action)
      ActToI64, ActToI64T, ActToI32, ActToI32T: cv = ci;
      ActToDbl: cv = cd;
      default:  cv = '0;
    endcase
    sum_d = sum_q; inx_d = inx_q; inv_d = inv_q;
    if (in_data_i.action == ActClear) begin
      sum_d = 1'b0; inx_d = 1'b0; inv_d = 1'b0;
    end
    if (cv.inv) begin
      if (!inv_d) sum_d = 1'b1;
      inv_d = 1'b1;
    end
    if (cv.fi) begin
      if (!inx_d) sum_d = 1'b1;
      inx_d = 1'b1;
    end
    out_d = {cv.res, cv.fi, cv.fr, cv.inv, sum_d, inx_d, inv_d};
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= RmNearest;
      vld_q  <= 1'b0;
      sum_q  <= 1'b0;
      inx_q  <= 1'b0;
      inv_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) mode_q <= cfg_data_i;
      if (take) begin
        vld_q <= 1'b1;
        sum_q <= sum_d; inx_q <= inx_d; inv_q <= inv_d;
      end else if (!out_stall_i) begin
        vld_q <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (take) out_q <= out_d;
  end

  assign out_valid_o = vld_q;
  assign out_data_o  = out_q;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q && out_stall_i |=> vld_q && $stable(out_q))
    else $error("stalled result changed");
  a_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q |-> out_q.invalid_flag == inv_q && out_q.inexact_flag == inx_q)
    else $error("reported flags differ from sticky state");
  a_inv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q && out_q.invalid_now |-> out_q.invalid_flag && !out_q.fraction_inexact)
    else $error("invalid result inconsistent");

endmodule
